[src/hsr_pkg.sv]
package hsr_pkg;

    // Width of the configuration registers, the counters and the length field.
    localparam int unsigned CNT_W = 16;

    // Register map (byte addresses, 32-bit data).
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned NUM_REGS = 2;

    typedef enum logic [0:0] {
        REG_BIT_PERIOD   = 1'b0,
        REG_ANSWER_DELAY = 1'b1
    } t_reg_idx;

    localparam logic [CNT_W-1:0] BIT_PERIOD_RST   = 16'd125;
    localparam logic [CNT_W-1:0] ANSWER_DELAY_RST = 16'd10;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_NONE  = 2'd0,
        ST_DONE  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

endpackage

[src/handshake_serial_receiver.sv]
// Receiver side of a timed two-wire handshake serial link. Each input transfer
// is one time tick carrying the sampled receive-line level (i_rx_level); each
// tick produces exactly one result transfer carrying the answer-line level
// after that tick, a data-bit strobe with value and last flag, a status code
// (none / message done / empty message) and the length field received so far.
// Sequence: idle with the line seen high -> answer line up, wait
// answer_delay_ticks, sample LENGTH_FIELD_BITS length bits LSB first one bit
// period apart, drop the answer line; a zero length ends with ST_EMPTY,
// otherwise one bit period answer pulse, then that many data bits, the last
// flagged with ST_DONE. Rate: one tick per clock cycle while the result
// channel accepts; each result is registered and appears in the cycle after
// its input transfer. The whole per-tick update is the state registers'
// next-state logic (one 16-bit down counter and 16-bit compares), then a
// result register. Registers via APB: 0x0 bit_period_ticks (0 acts as 1),
// 0x4 answer_delay_ticks; change them only while the link is idle.
module handshake_serial_receiver
    import hsr_pkg::*;
#(
    parameter int unsigned LENGTH_FIELD_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // tick input channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_rx_level,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_answer_line,
    output logic              o_bit_valid,
    output logic              o_bit_value,
    output logic              o_bit_last,
    output logic [1:0]        o_status,
    output logic [CNT_W-1:0]  o_message_length,
    // APB configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // Bits needed to address one bit of the length register.
    localparam int unsigned LIDX_W = $clog2(CNT_W);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_LENGTH = 3'd1,   // answer high, sampling length bits
        PH_RAISE  = 3'd2,   // one tick: raise answer for the pulse
        PH_PULSE  = 3'd3,   // answer pulse, one bit period
        PH_DATA   = 3'd4    // sampling data bits
    } t_phase;

    // configuration
    logic [CNT_W-1:0] r_bit_period;
    logic [CNT_W-1:0] r_answer_delay;

    // link state
    t_phase           r_phase,     n_phase;
    logic [CNT_W-1:0] r_tick,      n_tick;
    logic [CNT_W-1:0] r_bit_index, n_bit_index;
    logic [CNT_W-1:0] r_len,       n_len;
    logic             r_answer,    n_answer;

    // per-tick result before the output register
    logic    n_bit_valid;
    logic    n_bit_value;
    logic    n_bit_last;
    t_status n_status;

    // output register
    logic             r_out_valid;
    logic             r_out_answer;
    logic             r_out_bit_valid;
    logic             r_out_bit_value;
    logic             r_out_bit_last;
    t_status          r_out_status;
    logic [CNT_W-1:0] r_out_len;

    logic             in_xfer;
    logic             cfg_wr;
    logic [CNT_W-1:0] period_reload;
    logic [CNT_W-1:0] bit_index_inc;

    // Output register frees up whenever its content is taken this cycle.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        unique case (t_reg_idx'(paddr[2]))
            REG_BIT_PERIOD:   prdata[CNT_W-1:0] = r_bit_period;
            REG_ANSWER_DELAY: prdata[CNT_W-1:0] = r_answer_delay;
            default:          prdata = '0;
        endcase
    end

    // Counter reload for one bit period; zero period behaves like one.
    assign period_reload = (r_bit_period == '0) ? '0 : r_bit_period - 1'b1;
    assign bit_index_inc = r_bit_index + 1'b1;

    // Next-state logic for one tick.
    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_bit_index = r_bit_index;
        n_len       = r_len;
        n_answer    = r_answer;
        n_bit_valid = 1'b0;
        n_bit_value = 1'b0;
        n_bit_last  = 1'b0;
        n_status    = ST_NONE;

        unique case (r_phase)
            PH_IDLE: begin
                if (i_rx_level) begin
                    n_answer    = 1'b1;
                    n_phase     = PH_LENGTH;
                    n_tick      = r_answer_delay;
                    n_bit_index = '0;
                    n_len       = '0;
                end
            end
            PH_RAISE: begin
                n_answer = 1'b1;
                n_phase  = PH_PULSE;
                n_tick   = period_reload;
            end
            PH_LENGTH: begin
                if (r_tick != '0) begin
                    n_tick = r_tick - 1'b1;
                end else if (r_bit_index < CNT_W'(LENGTH_FIELD_BITS)) begin
                    n_len = r_len
                          | (CNT_W'(i_rx_level) << r_bit_index[LIDX_W-1:0]);
                    n_bit_index = bit_index_inc;
                    n_tick      = period_reload;
                end else begin
                    // bit period after the last length bit
                    n_answer    = 1'b0;
                    n_bit_index = '0;
                    if (r_len == '0) begin
                        n_status = ST_EMPTY;
                        n_phase  = PH_IDLE;
                    end else begin
                        n_phase = PH_RAISE;
                    end
                end
            end
            PH_PULSE: begin
                if (r_tick != '0) begin
                    n_tick = r_tick - 1'b1;
                end else begin
                    // pulse ends and the first data bit is sampled at once;
                    // length is nonzero here
                    n_answer    = 1'b0;
                    n_phase     = PH_DATA;
                    n_bit_valid = 1'b1;
                    n_bit_value = i_rx_level;
                    n_bit_index = CNT_W'(1);
                    n_tick      = period_reload;
                    if (r_len == CNT_W'(1)) begin
                        n_bit_last = 1'b1;
                        n_status   = ST_DONE;
                    end
                end
            end
            PH_DATA: begin
                if (r_tick != '0) begin
                    n_tick = r_tick - 1'b1;
                end else if (r_bit_index < r_len) begin
                    n_bit_valid = 1'b1;
                    n_bit_value = i_rx_level;
                    n_bit_index = bit_index_inc;
                    n_tick      = period_reload;
                    if (bit_index_inc == r_len) begin
                        n_bit_last = 1'b1;
                        n_status   = ST_DONE;
                    end
                end else begin
                    n_phase     = PH_IDLE;
                    n_tick      = '0;
                    n_bit_index = '0;
                end
            end
            default: begin
                // unused phase code: back to idle
                n_phase  = PH_IDLE;
                n_tick   = '0;
                n_answer = 1'b0;
            end
        endcase
    end

    // State, configuration and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period   <= BIT_PERIOD_RST;
            r_answer_delay <= ANSWER_DELAY_RST;
            r_phase        <= PH_IDLE;
            r_tick         <= '0;
            r_bit_index    <= '0;
            r_len          <= '0;
            r_answer       <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (t_reg_idx'(paddr[2]))
                    REG_BIT_PERIOD:   r_bit_period   <= pwdata[CNT_W-1:0];
                    REG_ANSWER_DELAY: r_answer_delay <= pwdata[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (in_xfer) begin
                r_phase     <= n_phase;
                r_tick      <= n_tick;
                r_bit_index <= n_bit_index;
                r_len       <= n_len;
                r_answer    <= n_answer;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        // result payload, no reset needed
        if (in_xfer) begin
            r_out_answer    <= n_answer;
            r_out_bit_valid <= n_bit_valid;
            r_out_bit_value <= n_bit_value;
            r_out_bit_last  <= n_bit_last;
            r_out_status    <= n_status;
            r_out_len       <= n_len;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_answer_line    = r_out_answer;
    assign o_bit_valid      = r_out_bit_valid;
    assign o_bit_value      = r_out_bit_value;
    assign o_bit_last       = r_out_bit_last;
    assign o_status         = r_out_status;
    assign o_message_length = r_out_len;

`ifndef ASSERT_OFF
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_phase == PH_IDLE) && !r_answer && !r_out_valid)
        else $error("state not cleared by reset");

    a_answer_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_LENGTH) || (r_phase == PH_PULSE)) |-> r_answer)
        else $error("answer line low during length or pulse phase");

    a_answer_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_IDLE) || (r_phase == PH_RAISE) || (r_phase == PH_DATA))
        |-> !r_answer)
        else $error("answer line high outside length or pulse phase");

    a_len_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LENGTH) |-> (r_bit_index <= CNT_W'(LENGTH_FIELD_BITS)))
        else $error("length bit index out of range");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_bit_last) |-> r_out_bit_valid
                                           && (r_out_status == ST_DONE))
        else $error("last flag without a data bit and done status");
`endif

endmodule
